// ===== sv/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants and types for the tachometer PI speed controller.
// ----------------------------------------------------------------------------
package tps_pkg;

    // Event codes
    localparam logic [1:0] OP_CAPTURE = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SPAN  = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_MIN_PERIOD    = 16'd1000;
    localparam logic [14:0] RST_MAX_PERIOD    = 15'd10000;
    localparam logic [14:0] RST_TARGET_PERIOD = 15'd8000;
    localparam logic [14:0] RST_LOCK_WINDOW   = 15'd40;
    localparam logic [11:0] RST_LOCK_TICKS    = 12'd2000;
    localparam logic [15:0] RST_TIMEOUT_SPAN  = 16'd32768;

    // Integral scaling: divisor must be a power of two (1..256)
    localparam int INTEGRAL_DIVISOR = 32;
    localparam int DIV_SH  = $clog2(INTEGRAL_DIVISOR);
    localparam int INT_LIM = INTEGRAL_DIVISOR * 256;
    localparam int INT_W   = $clog2(INT_LIM) + 2;
    localparam int SUM_W   = ((INT_W > 16) ? INT_W : 16) + 1;

    localparam logic [7:0] DUTY_FULL = 8'd255;

    typedef logic signed [INT_W-1:0] t_integral;
    typedef logic signed [SUM_W-1:0] t_sum;

endpackage

// ===== sv/tps_evt_if.sv =====
// ----------------------------------------------------------------------------
// tps_evt_if
// Event channel: valid/ready handshake with one controller event per beat.
// ----------------------------------------------------------------------------
interface tps_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] timestamp;
    logic        enable_request;

    modport source (output valid, operation, timestamp, enable_request, input ready);
    modport sink   (input valid, operation, timestamp, enable_request, output ready);
endinterface

// ===== sv/tps_res_if.sv =====
// ----------------------------------------------------------------------------
// tps_res_if
// Result channel: valid/ready handshake with one controller status per beat.
// ----------------------------------------------------------------------------
interface tps_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  duty;
    logic        speed_ok;
    logic        lock_out;
    logic [15:0] timeout_at;

    modport source (output valid, duty, speed_ok, lock_out, timeout_at, input ready);
    modport sink   (input valid, duty, speed_ok, lock_out, timeout_at, output ready);
endinterface

// ===== sv/tacho_pi_speed_controller.sv =====
// ----------------------------------------------------------------------------
// tacho_pi_speed_controller: PI motor speed control from tachometer periods.
// Takes one event per cycle unless a stalled result beat holds the result register.
// The input register feeds one pass of update logic into the result register.
// Synchronous active-low reset clears state, config returns to defaults.
// ----------------------------------------------------------------------------
module tacho_pi_speed_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tps_evt_if.sink                     i_evt,
    tps_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tps_pkg::*;

    // Configuration registers
    logic [15:0] r_min_period;
    logic [14:0] r_max_period;
    logic [14:0] r_target_period;
    logic [14:0] r_lock_window;
    logic [11:0] r_lock_ticks;
    logic [15:0] r_timeout_span;

    // Controller state
    logic [15:0] r_last_capture, n_last_capture;
    logic        r_timed_out,    n_timed_out;
    logic        r_speed_ok,     n_speed_ok;
    logic        r_running,      n_running;
    t_integral   r_integral,     n_integral;
    logic [11:0] r_correct_cnt,  n_correct_cnt;
    logic        r_locked,       n_locked;
    logic [15:0] r_compare,      n_compare;
    logic [7:0]  r_duty,         n_duty;

    // Input register
    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [15:0] r_s1_ts;
    logic        r_s1_en;

    // Result register
    logic        r_s2_valid;
    logic [7:0]  r_s2_duty;
    logic        r_s2_speed_ok;
    logic        r_s2_lock;
    logic [15:0] r_s2_timeout_at;

    logic s1_move;
    logic s1_load;

    // Datapath intermediates
    logic [15:0]        period;
    logic [14:0]        period_clamp;
    logic signed [15:0] err;
    logic signed [15:0] lw_s;
    t_sum               isum;
    t_integral          iclamp;
    t_integral          quot;
    t_sum               dsum;
    logic [7:0]         duty_calc;
    logic [12:0]        cnt_inc;

    assign s1_move     = r_s1_valid && (!r_s2_valid || o_res.ready);
    assign s1_load     = i_evt.valid && i_evt.ready;
    assign i_evt.ready = !r_s1_valid || s1_move;

    // Capture arithmetic
    always_comb begin
        period       = r_s1_ts - r_last_capture;
        period_clamp = (period > {1'b0, r_max_period}) ? r_max_period : period[14:0];
        err          = $signed({1'b0, period_clamp}) - $signed({1'b0, r_target_period});
        lw_s         = $signed({1'b0, r_lock_window});
        isum         = t_sum'(r_integral) + t_sum'(err);
        if (isum > t_sum'(INT_LIM)) begin
            iclamp = t_integral'(INT_LIM);
        end else if (isum < -t_sum'(INT_LIM)) begin
            iclamp = -t_integral'(INT_LIM);
        end else begin
            iclamp = isum[INT_W-1:0];
        end
        // Truncate toward zero: bias negatives before the shift
        quot = (iclamp + (iclamp[INT_W-1] ? t_integral'(INTEGRAL_DIVISOR - 1)
                                          : t_integral'(0))) >>> DIV_SH;
        dsum = t_sum'(err) + t_sum'(quot);
        if (dsum[SUM_W-1]) begin
            duty_calc = 8'd0;
        end else if (dsum > t_sum'(DUTY_FULL)) begin
            duty_calc = DUTY_FULL;
        end else begin
            duty_calc = dsum[7:0];
        end
        cnt_inc = {1'b0, r_correct_cnt} + 13'd1;
    end

    // Next state for the event in the input register
    always_comb begin
        n_last_capture = r_last_capture;
        n_timed_out    = r_timed_out;
        n_speed_ok     = r_speed_ok;
        n_running      = r_running;
        n_integral     = r_integral;
        n_correct_cnt  = r_correct_cnt;
        n_locked       = r_locked;
        n_compare      = r_compare;
        n_duty         = r_duty;
        case (r_s1_op)
            OP_CAPTURE: begin
                if (period >= r_min_period) begin
                    n_last_capture = r_s1_ts;
                    n_speed_ok     = 1'b0;
                    n_compare      = r_s1_ts + r_timeout_span;
                    if (r_timed_out) begin
                        n_timed_out = 1'b0;
                    end else begin
                        n_speed_ok = (err < lw_s) && (err > -lw_s);
                        n_integral = iclamp;
                        if (r_running) begin
                            n_duty = duty_calc;
                        end
                    end
                end
            end
            OP_TIMEOUT: begin
                if (r_running) begin
                    n_duty = DUTY_FULL;
                end
                n_timed_out = 1'b1;
                n_compare   = {~r_compare[15], r_compare[14:0]};
            end
            OP_TICK: begin
                if (r_speed_ok) begin
                    if (cnt_inc > {1'b0, r_lock_ticks}) begin
                        n_correct_cnt = r_lock_ticks;
                        n_locked      = 1'b1;
                    end else begin
                        n_correct_cnt = cnt_inc[11:0];
                    end
                end else begin
                    n_correct_cnt = 12'd0;
                    n_locked      = 1'b0;
                end
                if (r_s1_en) begin
                    n_running = 1'b1;
                end else begin
                    n_running     = 1'b0;
                    n_duty        = 8'd0;
                    n_correct_cnt = 12'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period    <= RST_MIN_PERIOD;
            r_max_period    <= RST_MAX_PERIOD;
            r_target_period <= RST_TARGET_PERIOD;
            r_lock_window   <= RST_LOCK_WINDOW;
            r_lock_ticks    <= RST_LOCK_TICKS;
            r_timeout_span  <= RST_TIMEOUT_SPAN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_PERIOD:    r_min_period    <= i_cfg_data;
                CFG_MAX_PERIOD:    r_max_period    <= i_cfg_data[14:0];
                CFG_TARGET_PERIOD: r_target_period <= i_cfg_data[14:0];
                CFG_LOCK_WINDOW:   r_lock_window   <= i_cfg_data[14:0];
                CFG_LOCK_TICKS:    r_lock_ticks    <= i_cfg_data[11:0];
                CFG_TIMEOUT_SPAN:  r_timeout_span  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Commit state as the event leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture <= '0;
            r_timed_out    <= 1'b0;
            r_speed_ok     <= 1'b0;
            r_running      <= 1'b0;
            r_integral     <= '0;
            r_correct_cnt  <= '0;
            r_locked       <= 1'b0;
            r_compare      <= '0;
            r_duty         <= '0;
        end else if (s1_move) begin
            r_last_capture <= n_last_capture;
            r_timed_out    <= n_timed_out;
            r_speed_ok     <= n_speed_ok;
            r_running      <= n_running;
            r_integral     <= n_integral;
            r_correct_cnt  <= n_correct_cnt;
            r_locked       <= n_locked;
            r_compare      <= n_compare;
            r_duty         <= n_duty;
        end
    end

    // Input register: take a beat whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_op <= i_evt.operation;
            r_s1_ts <= i_evt.timestamp;
            r_s1_en <= i_evt.enable_request;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_duty       <= n_duty;
            r_s2_speed_ok   <= n_speed_ok;
            r_s2_lock       <= n_running && n_locked;
            r_s2_timeout_at <= n_compare;
        end
    end

    assign o_res.valid      = r_s2_valid;
    assign o_res.duty       = r_s2_duty;
    assign o_res.speed_ok   = r_s2_speed_ok;
    assign o_res.lock_out   = r_s2_lock;
    assign o_res.timeout_at = r_s2_timeout_at;

endmodule

// ===== sv/tps_checker.sv =====
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks for the speed controller, attached by bind.
// ----------------------------------------------------------------------------
module tps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_duty,
    input logic [15:0] i_timeout_at
);
    logic [1:0] r_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Track events taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= r_pending + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_duty) && $stable(i_timeout_at))
        else $error("result payload changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result beat without a pending event");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 && !i_out_ready |-> !i_in_ready)
        else $error("event taken with both stages full and output stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind tacho_pi_speed_controller tps_checker u_tps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_evt.valid),
    .i_in_ready   (i_evt.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_duty       (o_res.duty),
    .i_timeout_at (o_res.timeout_at)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tachometer PI speed controller. A plan queue
// of events, setting writes, drains and idle-rate changes feeds a negedge
// driver. A posedge monitor steps a local controller model on every event
// beat and checks each status beat, field by field, against the oldest
// prediction. A directed opener is followed by random phases, each run under
// its own register settings.
// ----------------------------------------------------------------------------
module tb;
    import tps_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [15:0] TIMEOUT_REARM = 16'h8000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 10;
    localparam int WD_LIMIT      = 2000;
    localparam int MAX_REPORTS   = 100;

    typedef enum logic [1:0] {ITEM_EVENT, ITEM_CONFIG, ITEM_DRAIN, ITEM_PACE} t_plan_kind;

    typedef struct {
        t_plan_kind            kind;
        logic [1:0]            op;
        logic [15:0]           ts;
        logic                  en;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        int                    src_idle;
        int                    snk_idle;
    } t_plan_item;

    typedef struct packed {
        logic [7:0]  duty;
        logic        speed_ok;
        logic        lock_out;
        logic [15:0] timeout_at;
    } t_speed_status;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tps_evt_if evt_if ();
    tps_res_if res_if ();

    tacho_pi_speed_controller u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_plan_item    event_plan_q[$];
    t_speed_status pending_status_q[$];

    // Driver side
    int   src_idle_pct = 31;
    int   snk_idle_pct = 50;
    int   quiet_cycles = 0;
    logic evt_beat;

    // Monitor side
    int n_fail = 0;
    int n_results = 0;
    int n_captures = 0;
    int n_timeouts = 0;
    int n_ticks = 0;
    int n_unused = 0;
    int n_writes = 0;
    int n_ok_seen = 0;
    int n_lock_seen = 0;
    int idle_cycles = 0;

    // Controller model: settings
    logic [15:0] m_min_period;
    logic [14:0] m_max_period;
    logic [14:0] m_target;
    logic [14:0] m_window;
    logic [11:0] m_lock_ticks;
    logic [15:0] m_span;

    // Controller model: state
    logic [15:0] m_last_capture;
    logic        m_timed_out;
    logic        m_speed_ok;
    logic        m_running;
    int          m_integral;
    logic [11:0] m_count;
    logic        m_locked;
    logic [15:0] m_compare;
    logic [7:0]  m_duty;

    // Stimulus side mirror of what the generator needs
    logic [15:0] g_last = 16'd0;
    logic [15:0] g_min = RST_MIN_PERIOD;
    logic [14:0] g_target = RST_TARGET_PERIOD;
    logic [14:0] g_window = RST_LOCK_WINDOW;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    function automatic void clear_model();
        m_min_period   = RST_MIN_PERIOD;
        m_max_period   = RST_MAX_PERIOD;
        m_target       = RST_TARGET_PERIOD;
        m_window       = RST_LOCK_WINDOW;
        m_lock_ticks   = RST_LOCK_TICKS;
        m_span         = RST_TIMEOUT_SPAN;
        m_last_capture = '0;
        m_timed_out    = 1'b0;
        m_speed_ok     = 1'b0;
        m_running      = 1'b0;
        m_integral     = 0;
        m_count        = '0;
        m_locked       = 1'b0;
        m_compare      = '0;
        m_duty         = '0;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIN_PERIOD:    m_min_period = data;
            CFG_MAX_PERIOD:    m_max_period = data[14:0];
            CFG_TARGET_PERIOD: m_target     = data[14:0];
            CFG_LOCK_WINDOW:   m_window     = data[14:0];
            CFG_LOCK_TICKS:    m_lock_ticks = data[11:0];
            CFG_TIMEOUT_SPAN:  m_span       = data;
            default: ;
        endcase
    endfunction

    function automatic t_speed_status next_speed_status(logic [1:0] op, logic [15:0] ts,
                                                        logic en);
        t_speed_status st;
        logic [15:0]   period;
        int            per;
        int            err;
        int            drive;
        int            cnt;
        case (op)
            OP_CAPTURE: begin
                period = ts - m_last_capture;
                // Drop glitch pulses without touching anything
                if (period >= m_min_period) begin
                    m_last_capture = ts;
                    m_speed_ok     = 1'b0;
                    m_compare      = ts + m_span;
                    if (m_timed_out) begin
                        // Discard the first measurement after a stall
                        m_timed_out = 1'b0;
                    end else begin
                        per = (period > m_max_period) ? int'(m_max_period) : int'(period);
                        err = per - int'(m_target);
                        if (err < int'(m_window) && err > -int'(m_window))
                            m_speed_ok = 1'b1;
                        m_integral = m_integral + err;
                        if (m_integral > INT_LIM)
                            m_integral = INT_LIM;
                        if (m_integral < -INT_LIM)
                            m_integral = -INT_LIM;
                        drive = err + m_integral / INTEGRAL_DIVISOR;
                        if (drive > 255)
                            drive = 255;
                        if (drive < 0)
                            drive = 0;
                        if (m_running)
                            m_duty = drive[7:0];
                    end
                end
            end
            OP_TIMEOUT: begin
                if (m_running)
                    m_duty = DUTY_FULL;
                m_timed_out = 1'b1;
                m_compare   = m_compare + TIMEOUT_REARM;
            end
            OP_TICK: begin
                // Advance the lock counter, saturating at the threshold
                if (m_speed_ok) begin
                    cnt = int'(m_count) + 1;
                    if (cnt > int'(m_lock_ticks)) begin
                        cnt      = int'(m_lock_ticks);
                        m_locked = 1'b1;
                    end
                    m_count = cnt[11:0];
                end else begin
                    m_count  = '0;
                    m_locked = 1'b0;
                end
                if (en) begin
                    m_running = 1'b1;
                end else begin
                    m_running = 1'b0;
                    m_duty    = '0;
                    m_count   = '0;
                end
            end
            default: ;
        endcase
        st.duty       = m_duty;
        st.speed_ok   = m_speed_ok;
        st.lock_out   = m_running && m_locked;
        st.timeout_at = m_compare;
        return st;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("[%0t] status beat %0d: %s got %0d expected %0d",
                     $time, n_results, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // Plan builders
    // ------------------------------------------------------------------
    task automatic queue_event(input logic [1:0] op, input logic [15:0] ts, input logic en);
        t_plan_item it;
        logic [15:0] gap;
        it.kind = ITEM_EVENT;
        it.op = op;
        it.ts = ts;
        it.en = en;
        it.cfg_idx = '0;
        it.cfg_data = '0;
        it.src_idle = 0;
        it.snk_idle = 0;
        event_plan_q.push_back(it);
        // Track the last capture the block will keep
        gap = ts - g_last;
        if (op == OP_CAPTURE && gap >= g_min)
            g_last = ts;
    endtask

    task automatic queue_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        t_plan_item it;
        it.kind = ITEM_CONFIG;
        it.op = OP_CAPTURE;
        it.ts = '0;
        it.en = 1'b0;
        it.cfg_idx = idx;
        it.cfg_data = data;
        it.src_idle = 0;
        it.snk_idle = 0;
        event_plan_q.push_back(it);
        case (idx)
            CFG_MIN_PERIOD:    g_min = data;
            CFG_TARGET_PERIOD: g_target = data[14:0];
            CFG_LOCK_WINDOW:   g_window = data[14:0];
            default: ;
        endcase
    endtask

    task automatic queue_marker(input t_plan_kind kind, input int src_idle,
                                input int snk_idle);
        t_plan_item it;
        it.kind = kind;
        it.op = OP_CAPTURE;
        it.ts = '0;
        it.en = 1'b0;
        it.cfg_idx = '0;
        it.cfg_data = '0;
        it.src_idle = src_idle;
        it.snk_idle = snk_idle;
        event_plan_q.push_back(it);
    endtask

    task automatic queue_random_phase(input int n, input int src_idle, input int snk_idle,
                                      input int minp, input int maxp, input int target,
                                      input int win, input int lticks, input int span);
        int pick;
        int jit;
        int base;
        int win_j;
        logic [15:0] per;
        queue_marker(ITEM_PACE, src_idle, snk_idle);
        queue_setting(CFG_MIN_PERIOD, CFG_DATA_W'(minp));
        queue_setting(CFG_MAX_PERIOD, CFG_DATA_W'(maxp));
        queue_setting(CFG_TARGET_PERIOD, CFG_DATA_W'(target));
        queue_setting(CFG_LOCK_WINDOW, CFG_DATA_W'(win));
        queue_setting(CFG_LOCK_TICKS, CFG_DATA_W'(lticks));
        queue_setting(CFG_TIMEOUT_SPAN, CFG_DATA_W'(span));
        for (int k = 0; k < n; k++) begin
            // Hold the sender once per phase until all status beats are back
            if (k == n / 2)
                queue_marker(ITEM_DRAIN, 0, 0);
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Regular tacho pulse near the target period
                win_j = (g_window == 0) ? 16 : int'(g_window);
                base = (g_target == 0) ? 3000 : int'(g_target);
                if ($urandom_range(3) != 0)
                    jit = $urandom_range(2 * win_j) - win_j;
                else
                    jit = $urandom_range(16 * win_j) - 8 * win_j;
                per = 16'(base + jit);
                queue_event(OP_CAPTURE, g_last + per, 1'($urandom_range(1)));
            end else if (pick < 52) begin
                // Glitch pulse shorter than the minimum period
                per = (g_min == 0) ? 16'd0 : 16'($urandom_range(g_min - 1));
                queue_event(OP_CAPTURE, g_last + per, 1'($urandom_range(1)));
            end else if (pick < 57) begin
                if ($urandom_range(1))
                    per = 16'($urandom);
                else
                    per = 16'(g_min + $urandom_range(16'hFFFF - g_min));
                queue_event(OP_CAPTURE, g_last + per, 1'($urandom_range(1)));
            end else if (pick < 62) begin
                queue_event(OP_TIMEOUT, 16'($urandom), 1'($urandom_range(1)));
            end else if (pick < 96) begin
                queue_event(OP_TICK, 16'($urandom), $urandom_range(99) < 92);
            end else begin
                queue_event(OP_UNUSED, 16'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present event beats, setting writes and result back-pressure
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_plan_item head;
        logic hold;
        logic load;
        logic we_next;
        if (i_rst_n) begin
            load    = 1'b0;
            we_next = 1'b0;
            hold    = evt_if.valid && !evt_beat;
            if (pending_status_q.size() == 0 && !evt_if.valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!hold && event_plan_q.size() != 0) begin
                head = event_plan_q[0];
                case (head.kind)
                    ITEM_EVENT: begin
                        if ($urandom_range(99) >= src_idle_pct) begin
                            load = 1'b1;
                            void'(event_plan_q.pop_front());
                        end
                    end
                    ITEM_PACE: begin
                        src_idle_pct = head.src_idle;
                        snk_idle_pct = head.snk_idle;
                        void'(event_plan_q.pop_front());
                    end
                    default: begin
                        // Settings and drains wait for a quiet block
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            we_next = (head.kind == ITEM_CONFIG);
                            void'(event_plan_q.pop_front());
                        end
                    end
                endcase
            end
            evt_if.valid <= hold || load;
            if (load) begin
                evt_if.operation      <= head.op;
                evt_if.timestamp      <= head.ts;
                evt_if.enable_request <= head.en;
            end
            i_cfg_we <= we_next;
            if (we_next) begin
                i_cfg_idx  <= head.cfg_idx;
                i_cfg_data <= head.cfg_data;
            end
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: step the model on event beats, check status beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_speed_status want;
        if (!i_rst_n) begin
            clear_model();
            evt_beat <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (i_cfg_we) begin
                apply_setting(i_cfg_idx, i_cfg_data);
                n_writes++;
            end
            if (evt_if.valid && evt_if.ready) begin
                pending_status_q.push_back(next_speed_status(evt_if.operation,
                                                             evt_if.timestamp,
                                                             evt_if.enable_request));
                case (evt_if.operation)
                    OP_CAPTURE: n_captures++;
                    OP_TIMEOUT: n_timeouts++;
                    OP_TICK:    n_ticks++;
                    default:    n_unused++;
                endcase
            end
            evt_beat <= evt_if.valid && evt_if.ready;
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (pending_status_q.size() == 0) begin
                    flag_mismatch("unexpected beat, duty", res_if.duty, -1);
                end else begin
                    want = pending_status_q.pop_front();
                    if (res_if.duty !== want.duty)
                        flag_mismatch("duty", res_if.duty, want.duty);
                    if (res_if.speed_ok !== want.speed_ok)
                        flag_mismatch("speed_ok", res_if.speed_ok, want.speed_ok);
                    if (res_if.lock_out !== want.lock_out)
                        flag_mismatch("lock_out", res_if.lock_out, want.lock_out);
                    if (res_if.timeout_at !== want.timeout_at)
                        flag_mismatch("timeout_at", res_if.timeout_at, want.timeout_at);
                    if (want.speed_ok)
                        n_ok_seen++;
                    if (want.lock_out)
                        n_lock_seen++;
                end
            end
            if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        evt_if.valid          = 1'b0;
        evt_if.operation      = OP_CAPTURE;
        evt_if.timestamp      = '0;
        evt_if.enable_request = 1'b0;
        res_if.ready          = 1'b0;

        // Directed opener under reset settings, with a one-tick lock threshold
        queue_marker(ITEM_PACE, 31, 50);
        queue_setting(CFG_LOCK_TICKS, 16'd1);
        queue_event(OP_UNUSED, 16'hFFFF, 1'b1);
        queue_event(OP_CAPTURE, 16'd0, 1'b1);        // zero period glitch
        queue_event(OP_CAPTURE, 16'd999, 1'b0);      // just below the minimum
        queue_event(OP_TICK, 16'hFFFF, 1'b1);
        queue_event(OP_CAPTURE, 16'd8000, 1'b0);     // on target
        queue_event(OP_CAPTURE, 16'd16010, 1'b1);    // inside the window
        queue_event(OP_TICK, 16'd0, 1'b1);
        queue_event(OP_TICK, 16'd0, 1'b1);           // lock asserts here
        queue_event(OP_TICK, 16'hFFFF, 1'b0);        // disable drops duty
        queue_event(OP_CAPTURE, 16'd25010, 1'b1);    // capture while disabled
        queue_event(OP_TICK, 16'd0, 1'b1);
        queue_event(OP_TIMEOUT, 16'd0, 1'b1);        // full duty
        queue_event(OP_CAPTURE, 16'd33010, 1'b0);    // discarded after timeout
        queue_event(OP_CAPTURE, 16'd33009, 1'b1);    // longest period, clamped
        queue_event(OP_CAPTURE, 16'd34009, 1'b0);    // exactly the minimum
        queue_event(OP_UNUSED, 16'd0, 1'b0);
        queue_event(OP_TIMEOUT, 16'hFFFF, 1'b0);
        queue_event(OP_TIMEOUT, 16'h5A5A, 1'b1);     // compare wraps
        queue_event(OP_CAPTURE, 16'hFFFF, 1'b1);
        queue_event(OP_CAPTURE, 16'd7999, 1'b0);     // wraps past zero
        queue_event(OP_TICK, 16'd0, 1'b1);

        // Random phases; pacing moves from sender-light to receiver-light to none
        queue_random_phase(200, 31, 50, 1000, 10000, 8000, 40, 5, 32768);
        queue_setting(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        queue_setting(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        queue_random_phase(150, 31, 50, 0, 32767, 20000, 300, 0, 1);
        queue_random_phase(60, 50, 31, 65535, 5000, 4000, 100, 10, 65535);
        queue_random_phase(120, 50, 31, 500, 0, 0, 0, 4095, 1000);
        queue_random_phase(150, 0, 0, 200, 3000, 32767, 32767, 2, 40000);
        queue_random_phase(220, 0, 0, 800, 12000, 6000, 150, 3, 20000);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((event_plan_q.size() != 0 || evt_if.valid || pending_status_q.size() != 0)
               && idle_cycles < WD_LIMIT)
            @(negedge i_clk);

        if (idle_cycles >= WD_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d status beats outstanding",
                     WD_LIMIT, pending_status_q.size());
            $display("SCOREBOARD MISMATCH");
        end else begin
            repeat (TAIL_CYCLES) @(negedge i_clk);
            $display("Ran %0d captures, %0d timeout compares, %0d ticks, %0d unused codes,",
                     n_captures, n_timeouts, n_ticks, n_unused);
            $display("  %0d register writes; checked %0d status beats: %0d in window, %0d locked.",
                     n_writes, n_results, n_ok_seen, n_lock_seen);
            if (n_fail == 0 && pending_status_q.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule
